// File: hw/rtl/mck_pkg.sv
// Shared types, microcode store and Morse code table for the Morse keyer.
package mck_pkg;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [15:0] UnitLenReset = 16'd100;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
  } in_t;

  typedef struct packed {
    logic        key_level;
    logic [2:0]  units;
    logic [18:0] duration;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic       key_level;
    logic [2:0] units;
    logic       last_of_run;
  } emit_t;

  typedef struct packed {
    logic [3:0] len;
    logic [7:0] pat;
  } code_t;

  typedef logic [2:0] upc_t;

  localparam upc_t PcIdle    = 3'd0;
  localparam upc_t PcOn      = 3'd1;
  localparam upc_t PcOff     = 3'd2;
  localparam upc_t PcGap     = 3'd3;
  localparam upc_t PcEomWord = 3'd4;
  localparam upc_t PcEom     = 3'd5;
  localparam upc_t PcSpace   = 3'd6;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_END
  } jmp_t;

  typedef struct packed {
    logic       emit;
    logic       key_level;
    logic       dash_sel;
    logic [2:0] units;
    logic       last_of_run;
    logic       elem_step;
    logic       wo_set;
    logic       wo_clr;
    jmp_t       jmp;
    upc_t       target;
  } uword_t;

  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    w = '{emit: 1'b0, key_level: 1'b0, dash_sel: 1'b0, units: 3'd0, last_of_run: 1'b0,
          elem_step: 1'b0, wo_set: 1'b0, wo_clr: 1'b0, jmp: JMP_END, target: PcIdle};
    case (pc)
      PcOn: begin
        w.emit = 1'b1; w.key_level = 1'b1; w.dash_sel = 1'b1; w.units = 3'd1;
        w.jmp = JMP_NEXT;
      end
      PcOff: begin
        w.emit = 1'b1; w.units = 3'd1; w.elem_step = 1'b1;
        w.jmp = JMP_LOOP; w.target = PcOn;
      end
      PcGap: begin
        w.emit = 1'b1; w.units = 3'd2; w.last_of_run = 1'b1; w.wo_set = 1'b1;
      end
      PcEomWord: begin
        w.emit = 1'b1; w.units = 3'd4; w.jmp = JMP_NEXT;
      end
      PcEom: begin
        w.emit = 1'b1; w.units = 3'd6; w.last_of_run = 1'b1; w.wo_clr = 1'b1;
      end
      PcSpace: begin
        w.emit = 1'b1; w.units = 3'd4; w.last_of_run = 1'b1; w.wo_clr = 1'b1;
      end
      default: ;
    endcase
    return w;
  endfunction

  // pat: first element in bit 7, 1 = dash
  function automatic code_t code_lookup(input logic [7:0] ch);
    logic [7:0] c;
    code_t r;
    c = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      c = ch - 8'h20;
    end
    case (c)
      8'h41: r = '{4'd2, 8'b01000000};
      8'h42: r = '{4'd4, 8'b10000000};
      8'h43: r = '{4'd4, 8'b10100000};
      8'h44: r = '{4'd3, 8'b10000000};
      8'h45: r = '{4'd1, 8'b00000000};
      8'h46: r = '{4'd4, 8'b00100000};
      8'h47: r = '{4'd3, 8'b11000000};
      8'h48: r = '{4'd4, 8'b00000000};
      8'h49: r = '{4'd2, 8'b00000000};
      8'h4A: r = '{4'd4, 8'b01110000};
      8'h4B: r = '{4'd3, 8'b10100000};
      8'h4C: r = '{4'd4, 8'b01000000};
      8'h4D: r = '{4'd2, 8'b11000000};
      8'h4E: r = '{4'd2, 8'b10000000};
      8'h4F: r = '{4'd3, 8'b11100000};
      8'h50: r = '{4'd4, 8'b01100000};
      8'h51: r = '{4'd4, 8'b11010000};
      8'h52: r = '{4'd3, 8'b01000000};
      8'h53: r = '{4'd3, 8'b00000000};
      8'h54: r = '{4'd1, 8'b10000000};
      8'h55: r = '{4'd3, 8'b00100000};
      8'h56: r = '{4'd4, 8'b00010000};
      8'h57: r = '{4'd3, 8'b01100000};
      8'h58: r = '{4'd4, 8'b10010000};
      8'h59: r = '{4'd4, 8'b10110000};
      8'h5A: r = '{4'd4, 8'b11000000};
      8'h30: r = '{4'd5, 8'b11111000};
      8'h31: r = '{4'd5, 8'b01111000};
      8'h32: r = '{4'd5, 8'b00111000};
      8'h33: r = '{4'd5, 8'b00011000};
      8'h34: r = '{4'd5, 8'b00001000};
      8'h35: r = '{4'd5, 8'b00000000};
      8'h36: r = '{4'd5, 8'b10000000};
      8'h37: r = '{4'd5, 8'b11000000};
      8'h38: r = '{4'd5, 8'b11100000};
      8'h39: r = '{4'd5, 8'b11110000};
      8'h2E: r = '{4'd6, 8'b01010100};
      8'h2C: r = '{4'd6, 8'b11001100};
      8'h3F: r = '{4'd6, 8'b00110000};
      8'h27: r = '{4'd6, 8'b01111000};
      8'h21: r = '{4'd6, 8'b10101100};
      8'h2F: r = '{4'd5, 8'b10010000};
      8'h28: r = '{4'd5, 8'b10110000};
      8'h29: r = '{4'd6, 8'b10110100};
      8'h26: r = '{4'd5, 8'b01000000};
      8'h3A: r = '{4'd6, 8'b11100000};
      8'h3B: r = '{4'd6, 8'b10101000};
      8'h3D: r = '{4'd5, 8'b10001000};
      8'h2B: r = '{4'd5, 8'b01010000};
      8'h2D: r = '{4'd6, 8'b10000100};
      8'h5F: r = '{4'd6, 8'b00110100};
      8'h22: r = '{4'd6, 8'b01001000};
      8'h24: r = '{4'd7, 8'b00010010};
      8'h40: r = '{4'd6, 8'b01101000};
      default: r = '{4'd8, 8'b00000000};
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/mck_seq.sv
// Microcoded sequencer: dispatch, step counter, element registers and word state.
module mck_seq
  import mck_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  in_t   in_data,
  input  logic  hold,
  output logic  busy,
  output emit_t emit
);

  upc_t       pc_r, pc_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] pat_r, pat_nxt;
  logic       word_open_r, word_open_nxt;
  uword_t     uw;
  code_t      code;
  logic       advance;

  assign uw      = ucode_rom(pc_r);
  assign code    = code_lookup(in_data.char_code);
  assign busy    = (pc_r != PcIdle);
  assign advance = !(uw.emit && hold);

  always_comb begin
    emit.valid       = uw.emit;
    emit.key_level   = uw.key_level;
    emit.units       = (uw.dash_sel && pat_r[7]) ? 3'd3 : uw.units;
    emit.last_of_run = uw.last_of_run;
  end

  always_comb begin
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    pat_nxt       = pat_r;
    word_open_nxt = word_open_r;
    if (pc_r == PcIdle) begin
      if (start) begin
        if (in_data.command) begin
          pc_nxt = word_open_r ? PcEomWord : PcEom;
        end else if (in_data.char_code == CharSpace) begin
          pc_nxt = word_open_r ? PcSpace : PcIdle;
        end else begin
          pc_nxt  = PcOn;
          cnt_nxt = code.len;
          pat_nxt = code.pat;
        end
      end
    end else if (advance) begin
      if (uw.elem_step) begin
        cnt_nxt = cnt_r - 4'd1;
        pat_nxt = {pat_r[6:0], 1'b0};
      end
      if (uw.wo_set) begin
        word_open_nxt = 1'b1;
      end
      if (uw.wo_clr) begin
        word_open_nxt = 1'b0;
      end
      case (uw.jmp)
        JMP_NEXT: pc_nxt = pc_r + 3'd1;
        JMP_LOOP: pc_nxt = (cnt_r != 4'd1) ? uw.target : pc_r + 3'd1;
        JMP_END:  pc_nxt = PcIdle;
        default:  pc_nxt = PcIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PcIdle;
      word_open_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      word_open_r <= word_open_nxt;
    end
    cnt_r <= cnt_nxt;
    pat_r <= pat_nxt;
  end

  a_hold_pc: assert property (@(posedge clk) disable iff (!rst_n)
    uw.emit && hold |=> $stable(pc_r))
    else $error("step advanced while output held");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PcOn || pc_r == PcOff) |-> cnt_r != 4'd0)
    else $error("element loop with no elements left");

  a_gap_opens: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == PcGap && !hold |=> word_open_r && pc_r == PcIdle)
    else $error("character gap did not open word");

  a_eom_closes: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == PcEom && !hold |=> !word_open_r)
    else $error("end of message left word open");

endmodule

// File: hw/rtl/morse_code_keyer_top.sv
// Top level of the Morse keyer: config register, sequencer and output register.
//
// Input channel in_valid/in_stall/in_data carries one transaction per character
// byte or end-of-message command. Output channel out_valid/out_stall/out_data
// gives one transaction per timed key interval; last_of_run marks the final
// one for an input transaction. cfg_we/cfg_wdata set the dot unit length.
//
// in_stall is high while the sequencer runs a transaction. A character with
// n elements gives 2n+1 results, and the next transaction can be accepted in
// the cycle after its last result is loaded into the output register. The
// sequencer emits one result per microcode step and waits on a step while
// the output is stalled. The first result is registered at out_valid after
// the sequencer has left idle for its first step.
//
// Reset (rst_n low, synchronous) returns the sequencer to idle, closes the
// word and sets the unit length to 100. When the receiver stalls, the output
// register holds and the sequencer waits on its current step.
module morse_code_keyer_top
  import mck_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] unit_len_r;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;
  logic        busy;
  logic        hold;
  logic        load;
  emit_t       emit;

  assign hold = out_valid_r && out_stall;

  mck_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_valid),
    .in_data (in_data),
    .hold    (hold),
    .busy    (busy),
    .emit    (emit)
  );

  assign in_stall = busy;
  assign load     = emit.valid && !hold;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.key_level   = emit.key_level;
      out_data_nxt.units       = emit.units;
      out_data_nxt.duration    = 19'(emit.units) * 19'(unit_len_r);
      out_data_nxt.last_of_run = emit.last_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_len_r  <= UnitLenReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unit_len_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
